@@ design/jkv_pkg.sv @@
package jkv_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] value_byte;
    logic [1:0] status;
    logic [5:0] value_length;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [63:0] key_chars_low;
    logic [63:0] key_chars_high;
    logic [4:0]  key_length;
    logic [5:0]  value_capacity;
  } cfg_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_QUOTED,
    PH_BARE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    REG_KEY_LOW,
    REG_KEY_HIGH,
    REG_KEY_LENGTH,
    REG_VALUE_CAPACITY
  } reg_index_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOKEY = 2'd1;
  localparam logic [1:0] ST_OPEN  = 2'd2;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [5:0] CAPACITY_RESET = 6'd63;

  function automatic result_t mk_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.item_kind  = KIND_BYTE;
    r.value_byte = b;
    return r;
  endfunction

  function automatic result_t mk_status(input logic [1:0] st, input logic [5:0] len);
    result_t r;
    r = '0;
    r.item_kind    = KIND_STATUS;
    r.status       = st;
    r.value_length = len;
    return r;
  endfunction

endpackage

@@ design/jkv_parse.sv @@
module jkv_parse #(
  parameter int KEY_MAX   = 16,
  parameter int VALUE_MAX = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  jkv_pkg::text_t text,
  input  jkv_pkg::cfg_t  cfg,
  output jkv_pkg::push_t push
);
  import jkv_pkg::*;

  localparam int LW = $clog2(KEY_MAX + 1);
  localparam int CW = $clog2(VALUE_MAX);

  logic [7:0]    recent [0:KEY_MAX];
  logic [7:0]    key_at [0:KEY_MAX-1];
  phase_t        phase;
  logic [CW-1:0] cnt;
  logic          esc;

  logic [LW-1:0] len_c;
  logic [CW-1:0] cap;
  logic [7:0]    c;
  logic [7:0]    kb;
  logic          key_ok;
  logic          match;
  logic          blank;
  logic          do_take;
  logic          bare;
  logic          t_cap;
  logic          t_fin;
  logic [1:0]    t_st;
  logic          esc_next;
  phase_t        phase_next;
  logic [CW-1:0] cnt_next;
  logic          shift;
  logic          is_end;
  logic          e_fin;
  logic          e_cap;
  logic [1:0]    e_st;
  logic [CW-1:0] e_len;
  result_t       cand [0:3];
  logic [3:0]    cand_v;
  logic [1:0]    n;

  assign c     = text.text_byte;
  assign blank = (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF});

  always_comb begin
    if (32'(cfg.key_length) > KEY_MAX) begin
      len_c = LW'(KEY_MAX);
    end else begin
      len_c = LW'(cfg.key_length);
    end
    if (32'(cfg.value_capacity) > VALUE_MAX - 1) begin
      cap = CW'(VALUE_MAX - 1);
    end else begin
      cap = CW'(cfg.value_capacity);
    end
  end

  always_comb begin
    for (int k = 0; k < KEY_MAX; k++) begin
      if (k < 8) begin
        key_at[k] = cfg.key_chars_low[8*(k%8) +: 8];
      end else if (k < 16) begin
        key_at[k] = cfg.key_chars_high[8*(k%8) +: 8];
      end else begin
        key_at[k] = '0;
      end
    end
  end

  always_comb begin
    key_ok = 1'b1;
    kb     = '0;
    for (int j = 0; j < KEY_MAX; j++) begin
      kb = '0;
      for (int k = 0; k < KEY_MAX; k++) begin
        if (j + k + 1 == int'(len_c)) kb = key_at[k];
      end
      if (j < int'(len_c) && recent[j] != kb) key_ok = 1'b0;
    end
    match = (c == CH_QUOTE) && (recent[len_c] == CH_QUOTE) && key_ok;
  end

  always_comb begin
    do_take    = take && (c != '0) && (phase != PH_DONE);
    t_cap      = 1'b0;
    t_fin      = 1'b0;
    t_st       = ST_OK;
    esc_next   = esc;
    phase_next = phase;
    shift      = 1'b0;
    bare       = 1'b0;
    if (do_take) begin
      case (phase)
        PH_SEARCH: begin
          shift = 1'b1;
          if (match) phase_next = PH_SKIP;
        end
        PH_SKIP: begin
          if (blank || c == CH_COLON) begin
            phase_next = PH_SKIP;
          end else if (c == CH_QUOTE) begin
            phase_next = PH_QUOTED;
          end else begin
            phase_next = PH_BARE;
            bare       = 1'b1;
          end
        end
        PH_QUOTED: begin
          if (esc) begin
            esc_next = 1'b0;
            t_cap    = 1'b1;
          end else if (c == CH_QUOTE) begin
            t_fin = 1'b1;
          end else if (cnt >= cap) begin
            t_fin = 1'b1;
            t_st  = ST_OPEN;
          end else if (c == CH_BSLASH) begin
            esc_next = 1'b1;
          end else begin
            t_cap = 1'b1;
          end
        end
        PH_BARE: begin
          bare = 1'b1;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
    if (bare) begin
      if (c == CH_COMMA || c == CH_RBRACE || blank || cnt >= cap) begin
        t_fin = 1'b1;
      end else begin
        t_cap = 1'b1;
        if ({1'b0, cnt} + 1'b1 >= {1'b0, cap}) t_fin = 1'b1;
      end
    end
    if (t_fin) phase_next = PH_DONE;
    cnt_next = cnt + CW'(t_cap);
    is_end   = take && ((c == '0) || text.end_of_text);
    e_fin    = is_end && (phase_next != PH_DONE);
    e_cap    = e_fin && (phase_next == PH_QUOTED) && esc_next;
    case (phase_next)
      PH_SEARCH: e_st = ST_NOKEY;
      PH_QUOTED: e_st = ST_OPEN;
      default:   e_st = ST_OK;
    endcase
    e_len = cnt_next + CW'(e_cap);
  end

  always_comb begin
    cand[0] = mk_byte(c);
    cand[1] = mk_status(t_st, 6'(cnt_next));
    cand[2] = mk_byte(CH_BSLASH);
    cand[3] = mk_status(e_st, 6'(e_len));
    cand_v  = {e_fin, e_cap, t_fin, t_cap};
    push    = '0;
    n       = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (n == 2'd0) begin
          push.r0 = cand[i];
        end else begin
          push.r1 = cand[i];
        end
        n = n + 2'd1;
      end
    end
    push.count = n;
    if (n == 2'd1) push.r0.run_last = 1'b1;
    if (n == 2'd2) push.r1.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      cnt   <= '0;
      esc   <= 1'b0;
      for (int i = 0; i <= KEY_MAX; i++) recent[i] <= '0;
    end else if (take) begin
      if (is_end) begin
        phase <= PH_SEARCH;
        cnt   <= '0;
        esc   <= 1'b0;
        for (int i = 0; i <= KEY_MAX; i++) recent[i] <= '0;
      end else begin
        phase <= phase_next;
        cnt   <= cnt_next;
        esc   <= esc_next;
        if (shift) begin
          for (int i = KEY_MAX; i > 0; i--) recent[i] <= recent[i-1];
          recent[0] <= c;
        end
      end
    end
  end

`ifndef SYNTH
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && is_end |=> phase == PH_SEARCH && cnt == '0 && !esc)
    else $error("document end did not clear parser state");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_DONE && c != '0 && !text.end_of_text |-> push.count == 2'd0)
    else $error("result produced after status was sent");

  a_escape_in_quote: assert property (@(posedge clk) disable iff (rst)
    esc |-> phase == PH_QUOTED)
    else $error("escape pending outside quoted value");
`endif

endmodule

@@ design/jkv_outq.sv @@
module jkv_outq (
  input  logic             clk,
  input  logic             rst,
  input  jkv_pkg::push_t   push,
  output logic             full,
  output logic             result_valid,
  input  logic             result_stall,
  output jkv_pkg::result_t result
);
  import jkv_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  result_t        q [0:DEPTH-1];
  logic [AW-1:0]  head;
  logic [AW-1:0]  tail;
  logic [AW:0]    count;
  logic [AW:0]    count_next;
  logic           pop;

  assign full         = count > (AW+1)'(DEPTH - 2);
  assign result_valid = count != '0;
  assign result       = q[head];
  assign pop          = result_valid && !result_stall;
  assign count_next   = count + (AW+1)'(push.count) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) q[tail] <= push.r0;
    if (push.count == 2'd2) q[tail + AW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + AW'(pop);
      tail  <= tail + AW'(push.count);
      count <= count_next;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= (AW+1)'(DEPTH - 2))
    else $error("push without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 && !pop |=> count == $past(count) + (AW+1)'($past(push.count)))
    else $error("queue fill count lost a transaction");
`endif

endmodule

@@ design/json_key_value_extractor_core.sv @@
// Channel | Handshake                | Payload
// text    | text_valid / text_stall  | jkv_pkg::text_t (text_byte, end_of_text)
// result  | result_valid / result_stall | jkv_pkg::result_t
// cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One text byte per cycle while text_stall is low; its results land in a
// four-entry result queue on the accepting edge and reach the queue head
// behind any earlier results. An item yields zero to two results; the queue
// drains one per cycle without result_stall, so two-result bursts stall text.
// text_stall rises when fewer than two queue entries are free.
// rst is synchronous: key cleared, capacity 63, parser searching, queue empty.
module json_key_value_extractor_core #(
  parameter int KEY_MAX   = 16,
  parameter int VALUE_MAX = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_stall,
  input  jkv_pkg::text_t   text,
  output logic             result_valid,
  input  logic             result_stall,
  output jkv_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data
);
  import jkv_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  full;
  logic  take;

  assign cfg_ready  = 1'b1;
  assign text_stall = full;
  assign take       = text_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_chars_low  <= '0;
      cfg.key_chars_high <= '0;
      cfg.key_length     <= '0;
      cfg.value_capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_KEY_LOW:        cfg.key_chars_low  <= cfg_data;
        REG_KEY_HIGH:       cfg.key_chars_high <= cfg_data;
        REG_KEY_LENGTH:     cfg.key_length     <= cfg_data[4:0];
        REG_VALUE_CAPACITY: cfg.value_capacity <= cfg_data[5:0];
        default:            cfg.key_length     <= cfg.key_length;
      endcase
    end
  end

  jkv_parse #(
    .KEY_MAX   (KEY_MAX),
    .VALUE_MAX (VALUE_MAX)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .text (text),
    .cfg  (cfg),
    .push (push)
  );

  jkv_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
